@@ rtl/joint_lag_rate_limit_observer_assert.svh @@
// Assertion macros for the joint lag observer.
// Included by the top level; expects clk and rst in scope where used.
`ifndef JOINT_LAG_RATE_LIMIT_OBSERVER_ASSERT_SVH
`define JOINT_LAG_RATE_LIMIT_OBSERVER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define JLRLO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define JLRLO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JLRLO_ASSERT_NOW(lbl, ante, cons, msg)
`define JLRLO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/jlrlo_pkg.sv @@
// Shared types and constants for the joint lag observer.
// No dependencies; imported by every module of the block.
package jlrlo_pkg;

  localparam int LEG_W        = 3;
  localparam int JOINT_W      = 2;
  localparam int GAIN_W       = 16;
  localparam int LIMIT_W      = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int GAIN_FRAC    = 15;

  localparam int LEG_COUNT_DEF      = 6;
  localparam int JOINTS_PER_LEG_DEF = 3;
  localparam int POS_WIDTH_DEF      = 16;

  // Q1.15 unity gain, one bit wider than the register.
  localparam logic [GAIN_W:0] GAIN_ONE = (GAIN_W + 1)'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAG_GAIN   = 2'd0,
    REG_RISE_LIMIT = 2'd1,
    REG_FALL_LIMIT = 2'd2,
    REG_DEADBAND   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  lag_gain;
    logic [LIMIT_W-1:0] rise_step_limit;
    logic [LIMIT_W-1:0] fall_step_limit;
    logic [LIMIT_W-1:0] deadband;
  } cfg_t;

endpackage

@@ rtl/jlrlo_cfg.sv @@
// Configuration register file for the joint lag observer.
// Depends on jlrlo_pkg for the register index codes and cfg_t.
module jlrlo_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [jlrlo_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [jlrlo_pkg::CFG_DATA_W-1:0] wr_data,
  output jlrlo_pkg::cfg_t                 cfg
);
  import jlrlo_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lag_gain        <= GAIN_ONE[GAIN_W-1:0];
      cfg.rise_step_limit <= '0;
      cfg.fall_step_limit <= '0;
      cfg.deadband        <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_LAG_GAIN:   cfg.lag_gain        <= wr_data[GAIN_W-1:0];
        REG_RISE_LIMIT: cfg.rise_step_limit <= wr_data[LIMIT_W-1:0];
        REG_FALL_LIMIT: cfg.fall_step_limit <= wr_data[LIMIT_W-1:0];
        REG_DEADBAND:   cfg.deadband        <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/jlrlo_state.sv @@
// Per-joint estimate store and seeded flags for the joint lag observer.
// Depends on jlrlo_pkg only by convention; flags clear on reset.
module jlrlo_state #(
  parameter int JOINT_TOTAL = 18,
  parameter int POS_WIDTH   = 16,
  parameter int IDX_W       = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [IDX_W-1:0]            rd_idx,
  output logic signed [POS_WIDTH-1:0] rd_pos,
  output logic                        rd_seeded,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic signed [POS_WIDTH-1:0] wr_pos
);
  import jlrlo_pkg::*;

  logic signed [POS_WIDTH-1:0] pos_q [JOINT_TOTAL];
  logic [JOINT_TOTAL-1:0]      seeded;

  // Read data is only used for in-range indexes, once seeded.
  assign rd_pos    = pos_q[rd_idx];
  assign rd_seeded = seeded[rd_idx];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_q[wr_idx] <= wr_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= '0;
    end else if (wr_en) begin
      seeded[wr_idx] <= 1'b1;
    end
  end

endmodule

@@ rtl/jlrlo_update.sv @@
// Estimate update datapath: deadband, Q1.15 lag gain, step clamp, saturation.
// Depends on jlrlo_pkg for cfg_t and the gain constants. Pure logic.
module jlrlo_update #(
  parameter int POS_WIDTH = 16
) (
  input  jlrlo_pkg::cfg_t             cfg,
  input  logic signed [POS_WIDTH-1:0] target,
  input  logic signed [POS_WIDTH-1:0] est,
  input  logic                        seeded,
  output logic signed [POS_WIDTH-1:0] new_pos,
  output logic signed [POS_WIDTH:0]   velocity,
  output logic                        moving
);
  import jlrlo_pkg::*;

  localparam int EW = POS_WIDTH + 1;
  localparam int PW = POS_WIDTH + GAIN_W + 3;

  logic signed [EW-1:0] err;
  logic signed [PW-1:0] err_x, mag_x, gain_x, prod, delta, delta_c, lim_x;
  logic signed [PW-1:0] sum_x, next_x, pos_max_x, pos_min_x, diff_x;
  logic [GAIN_W:0]      gain_sat;
  logic [LIMIT_W-1:0]   lim;
  logic                 outside;

  always_comb begin
    err      = EW'(target) - EW'(est);
    err_x    = PW'(err);
    mag_x    = (err < 0) ? -err_x : err_x;
    outside  = mag_x > $signed(PW'(cfg.deadband));

    // Gain saturates at unity.
    gain_sat = ({1'b0, cfg.lag_gain} > GAIN_ONE) ? GAIN_ONE : {1'b0, cfg.lag_gain};
    gain_x   = $signed(PW'(gain_sat));
    prod     = err_x * gain_x;
    delta    = prod >>> GAIN_FRAC;

    lim      = (err >= 0) ? cfg.rise_step_limit : cfg.fall_step_limit;
    lim_x    = $signed(PW'(lim));
    delta_c  = delta;
    if (lim != '0) begin
      if (delta > lim_x) delta_c = lim_x;
      if (delta < -lim_x) delta_c = -lim_x;
    end

    pos_max_x = $signed(PW'({(POS_WIDTH-1){1'b1}}));
    pos_min_x = -pos_max_x - PW'(1);
    sum_x     = PW'(est) + delta_c;
    if (sum_x > pos_max_x) begin
      next_x = pos_max_x;
    end else if (sum_x < pos_min_x) begin
      next_x = pos_min_x;
    end else begin
      next_x = sum_x;
    end
    diff_x = next_x - PW'(est);

    if (!seeded) begin
      new_pos  = target;
      velocity = '0;
      moving   = 1'b0;
    end else if (!outside) begin
      new_pos  = est;
      velocity = '0;
      moving   = 1'b0;
    end else begin
      new_pos  = next_x[POS_WIDTH-1:0];
      velocity = diff_x[POS_WIDTH:0];
      moving   = 1'b1;
    end
  end

endmodule

@@ rtl/joint_lag_rate_limit_observer.sv @@
// Joint lag observer top level: input register, update logic, result register.
// Depends on jlrlo_pkg, jlrlo_cfg, jlrlo_state, jlrlo_update and the assert header.
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     s_tdata: leg, joint, target
//  m_*       out        m_tvalid / m_tready     m_tdata: leg, joint, est, vel, moving
//  cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Takes one item per cycle while the output is not stalled. An accepted item
// passes the input register, then the result register, before m_tvalid rises.
// The update path between them is one Q1.15 multiply plus clamp and saturate.
// A stalled output holds the result and the waiting input item; s_tready
// stays high as long as the input register can move on.
// rst is synchronous: it clears the seeded flags, the valid bits and the
// configuration to gain 1.0, no limits, no deadband.
`include "joint_lag_rate_limit_observer_assert.svh"
module joint_lag_rate_limit_observer #(
  parameter int LEG_COUNT      = jlrlo_pkg::LEG_COUNT_DEF,
  parameter int JOINTS_PER_LEG = jlrlo_pkg::JOINTS_PER_LEG_DEF,
  parameter int POS_WIDTH      = jlrlo_pkg::POS_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // leg_index, joint_index, target_position (lowest bits first), zero padded
  input  logic [((jlrlo_pkg::LEG_W + jlrlo_pkg::JOINT_W + POS_WIDTH + 7) / 8) * 8 - 1:0]
               s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_leg, out_joint, estimated_position, step_velocity, moving, zero padded
  output logic [((jlrlo_pkg::LEG_W + jlrlo_pkg::JOINT_W + 2 * POS_WIDTH + 2 + 7) / 8) * 8 - 1:0]
               m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jlrlo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jlrlo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jlrlo_pkg::*;

  localparam int JOINT_TOTAL = LEG_COUNT * JOINTS_PER_LEG;
  localparam int IDX_W       = (JOINT_TOTAL > 1) ? $clog2(JOINT_TOTAL) : 1;
  localparam int IDX_CALC_W  = LEG_W + JOINT_W + 4;
  localparam int TGT_LO      = LEG_W + JOINT_W;
  localparam int POS_LO      = LEG_W + JOINT_W;
  localparam int VEL_LO      = POS_LO + POS_WIDTH;
  localparam int MOV_BIT     = VEL_LO + POS_WIDTH + 1;

  cfg_t cfg;

  // Input register
  logic                        a_valid;
  logic [LEG_W-1:0]            a_leg;
  logic [JOINT_W-1:0]          a_joint;
  logic signed [POS_WIDTH-1:0] a_target;

  logic                        a_in_range;
  logic [IDX_CALC_W-1:0]       a_idx_wide;
  logic [IDX_W-1:0]            a_idx;
  logic                        out_free;
  logic                        go;

  logic signed [POS_WIDTH-1:0] st_pos;
  logic                        st_seeded;
  logic signed [POS_WIDTH-1:0] upd_pos;
  logic signed [POS_WIDTH:0]   upd_vel;
  logic                        upd_moving;

  // Result register
  logic [LEG_W-1:0]            r_leg;
  logic [JOINT_W-1:0]          r_joint;
  logic signed [POS_WIDTH-1:0] r_pos;
  logic signed [POS_WIDTH:0]   r_vel;
  logic                        r_moving;

  assign cfg_ready = 1'b1;

  jlrlo_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the input item once the result register can take its result.
  assign out_free = !m_tvalid || m_tready;
  assign go       = a_valid && out_free;
  assign s_tready = !a_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_leg    <= s_tdata[LEG_W-1:0];
      a_joint  <= s_tdata[LEG_W +: JOINT_W];
      a_target <= s_tdata[TGT_LO +: POS_WIDTH];
    end
  end

  // Out-of-range joints are dropped: no state change, no result.
  assign a_in_range = (IDX_CALC_W'(a_leg) < IDX_CALC_W'(LEG_COUNT)) &&
                      (IDX_CALC_W'(a_joint) < IDX_CALC_W'(JOINTS_PER_LEG));
  assign a_idx_wide = IDX_CALC_W'(a_leg) * IDX_CALC_W'(JOINTS_PER_LEG)
                      + IDX_CALC_W'(a_joint);
  assign a_idx      = a_idx_wide[IDX_W-1:0];

  jlrlo_state #(
    .JOINT_TOTAL (JOINT_TOTAL),
    .POS_WIDTH   (POS_WIDTH),
    .IDX_W       (IDX_W)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (a_idx),
    .rd_pos    (st_pos),
    .rd_seeded (st_seeded),
    .wr_en     (go && a_in_range),
    .wr_idx    (a_idx),
    .wr_pos    (upd_pos)
  );

  jlrlo_update #(
    .POS_WIDTH (POS_WIDTH)
  ) u_update (
    .cfg      (cfg),
    .target   (a_target),
    .est      (st_pos),
    .seeded   (st_seeded),
    .new_pos  (upd_pos),
    .velocity (upd_vel),
    .moving   (upd_moving)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= go && a_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (go && a_in_range) begin
      r_leg    <= a_leg;
      r_joint  <= a_joint;
      r_pos    <= upd_pos;
      r_vel    <= upd_vel;
      r_moving <= upd_moving;
    end
  end

  always_comb begin
    m_tdata                        = '0;
    m_tdata[LEG_W-1:0]             = r_leg;
    m_tdata[LEG_W +: JOINT_W]      = r_joint;
    m_tdata[POS_LO +: POS_WIDTH]   = r_pos;
    m_tdata[VEL_LO +: POS_WIDTH+1] = r_vel;
    m_tdata[MOV_BIT]               = r_moving;
  end

  // A result that did not move reports zero velocity.
  `JLRLO_ASSERT_NOW(a_still_zero_vel, m_tvalid && !r_moving, r_vel == '0, "still result with velocity")
  // A stalled result must back-pressure a waiting input item.
  `JLRLO_ASSERT_NOW(a_stall_blocks, a_valid && m_tvalid && !m_tready, !s_tready, "input taken while stalled")
  // An in-range item that advances shows up as a result next cycle.
  `JLRLO_ASSERT_NEXT(a_item_to_result, go && a_in_range, m_tvalid, "advanced item produced no result")

endmodule

@@ bench/joint_lag_rate_limit_observer_test.sv @@
// Self-checking bench for the joint lag observer: directed and random targets.
// Depends on jlrlo_pkg and the joint_lag_rate_limit_observer top level.
module joint_lag_rate_limit_observer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jlrlo_pkg::*;

  localparam int LEGS       = LEG_COUNT_DEF;
  localparam int JOINTS     = JOINTS_PER_LEG_DEF;
  localparam int POS_W      = POS_WIDTH_DEF;
  localparam int VEL_W      = POS_W + 1;
  localparam int JOINT_SLOTS = LEGS * JOINTS;
  localparam int IN_W  = ((LEG_W + JOINT_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W = ((LEG_W + JOINT_W + 2 * POS_W + 2 + 7) / 8) * 8;
  // Field offsets inside tdata, lowest bits first.
  localparam int JOINT_LSB  = LEG_W;
  localparam int POS_LSB    = LEG_W + JOINT_W;
  localparam int VEL_LSB    = POS_LSB + POS_W;
  localparam int MOVING_BIT = VEL_LSB + VEL_W;
  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam longint GAIN_UNITY = longint'(GAIN_ONE);
  // Two register stages plus margin; also covers items dropped as out of range.
  localparam int DRAIN_CYCLES = 6;
  localparam int STUCK_LIMIT  = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int LONG_HOLD_CYCLES = 200;

  typedef struct {
    logic [LEG_W-1:0]   leg;
    logic [JOINT_W-1:0] joint;
    logic [POS_W-1:0]   est;
    logic [VEL_W-1:0]   vel;
    logic               moving;
  } joint_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;   // leg_index, joint_index, target_position
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;       // out_leg, out_joint, estimated_position,
                                   // step_velocity, moving
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow configuration, starts at the reset values.
  logic [GAIN_W-1:0]  gain_reg = GAIN_W'(32768);
  logic [LIMIT_W-1:0] rise_reg = '0;
  logic [LIMIT_W-1:0] fall_reg = '0;
  logic [LIMIT_W-1:0] band_reg = '0;

  // Shadow joint state.
  logic signed [POS_W-1:0] est_store [JOINT_SLOTS];
  logic                    seeded [JOINT_SLOTS];

  joint_update_t pending_updates [$];

  int errors = 0;
  int stuck_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_request = 0;

  joint_lag_rate_limit_observer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < JOINT_SLOTS; i++) begin
      est_store[i] = '0;
      seeded[i] = 1'b0;
    end
  end

  // Work out the update that one accepted target causes and queue it.
  function automatic void advance_joint_estimate(logic [LEG_W-1:0] leg,
                                                 logic [JOINT_W-1:0] joint,
                                                 logic signed [POS_W-1:0] target);
    int slot;
    longint est, err, mag, gain, lim, delta, nxt;
    joint_update_t upd;
    // Out-of-range leg or joint: dropped silently.
    if (leg >= LEGS || joint >= JOINTS) return;
    slot = leg * JOINTS + joint;
    upd.leg = leg;
    upd.joint = joint;
    upd.vel = '0;
    upd.moving = 1'b0;
    if (!seeded[slot]) begin
      // First target seeds the estimate.
      seeded[slot] = 1'b1;
      est_store[slot] = target;
    end else begin
      est = longint'(est_store[slot]);
      err = longint'(target) - est;
      mag = (err < 0) ? -err : err;
      if (mag > longint'(band_reg)) begin
        gain = (longint'(gain_reg) > GAIN_UNITY) ? GAIN_UNITY : longint'(gain_reg);
        lim = (err >= 0) ? longint'(rise_reg) : longint'(fall_reg);
        // Arithmetic shift floors toward minus infinity.
        delta = (err * gain) >>> GAIN_FRAC;
        if (lim > 0) begin
          if (delta > lim) delta = lim;
          if (delta < -lim) delta = -lim;
        end
        nxt = est + delta;
        if (nxt > POS_MAX) nxt = POS_MAX;
        if (nxt < POS_MIN) nxt = POS_MIN;
        upd.vel = VEL_W'(nxt - est);
        upd.moving = 1'b1;
        est_store[slot] = POS_W'(nxt);
      end
    end
    upd.est = est_store[slot];
    pending_updates.push_back(upd);
  endfunction

  function automatic void check_field(string name, logic [VEL_W-1:0] want,
                                      logic [VEL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Monitor: shadow register writes, predict on input, check on output, watchdog.
  always @(posedge clk) begin
    joint_update_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_LAG_GAIN:   gain_reg = cfg_data[GAIN_W-1:0];
          REG_RISE_LIMIT: rise_reg = cfg_data[LIMIT_W-1:0];
          REG_FALL_LIMIT: fall_reg = cfg_data[LIMIT_W-1:0];
          REG_DEADBAND:   band_reg = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        advance_joint_estimate(s_tdata[LEG_W-1:0], s_tdata[JOINT_LSB +: JOINT_W],
                               s_tdata[POS_LSB +: POS_W]);
      if (m_tvalid && m_tready) begin
        if (pending_updates.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = pending_updates.pop_front();
          check_field("out_leg", VEL_W'(want.leg), VEL_W'(m_tdata[LEG_W-1:0]));
          check_field("out_joint", VEL_W'(want.joint),
                      VEL_W'(m_tdata[JOINT_LSB +: JOINT_W]));
          check_field("estimated_position", VEL_W'(want.est),
                      VEL_W'(m_tdata[POS_LSB +: POS_W]));
          check_field("step_velocity", want.vel, m_tdata[VEL_LSB +: VEL_W]);
          check_field("moving", VEL_W'(want.moving), VEL_W'(m_tdata[MOVING_BIT]));
        end
      end
      // Any transaction on any channel counts as progress.
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("joint_lag_rate_limit_observer_test: done, errors");
        $finish;
      end
    end
  end

  // Result receiver: random stall per result while rx_idle is set, or a long hold when requested.
  initial begin
    int wait_cycles;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        wait_cycles = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        wait_cycles = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Offer one target; returns at the falling edge after its transaction.
  task automatic offer_target(int leg, int joint, int target);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({POS_W'(target), JOINT_W'(joint), LEG_W'(leg)});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold off until nothing is expected, then let dropped items flush too.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(int gain, int rise, int fall, int band);
    wait_idle();
    write_register(REG_LAG_GAIN, gain);
    write_register(REG_RISE_LIMIT, rise);
    write_register(REG_FALL_LIMIT, fall);
    write_register(REG_DEADBAND, band);
  endtask

  // Seeding, full-scale swings, holding at zero error, and dropped items.
  task automatic test_seed_and_extremes();
    offer_target(0, 0, -32768);
    offer_target(0, 0, 32767);
    offer_target(0, 0, -32768);
    offer_target(5, 2, 32767);
    offer_target(6, 0, 0);
    offer_target(7, 3, -1);
    offer_target(2, 3, 5);
    offer_target(5, 2, 32767);
  endtask

  // Floor rounding at tiny gain, zero gain, and gain above unity.
  task automatic test_gain_rounding();
    set_config(1, 0, 0, 0);
    offer_target(0, 0, -32767);
    offer_target(0, 0, 32767);
    offer_target(0, 0, -32768);
    set_config(65535, 0, 0, 0);
    offer_target(1, 1, 1000);
    offer_target(1, 1, 3000);
    set_config(0, 0, 0, 0);
    offer_target(1, 1, -5000);
    set_config(16384, 0, 0, 0);
    offer_target(1, 1, 3001);
    offer_target(1, 1, 2990);
  endtask

  // Per-direction clamps, including the largest limit and a limit of one.
  task automatic test_step_limits();
    set_config(32768, 100, 50, 0);
    offer_target(2, 0, 0);
    offer_target(2, 0, 20000);
    offer_target(2, 0, -20000);
    set_config(32768, 32767, 1, 0);
    offer_target(2, 0, 32767);
    offer_target(2, 0, -32768);
  endtask

  // Errors on both sides of the deadband edge, and the widest deadband.
  task automatic test_deadband();
    set_config(32768, 0, 0, 10);
    offer_target(3, 1, 100);
    offer_target(3, 1, 110);
    offer_target(3, 1, 111);
    offer_target(3, 1, 101);
    offer_target(3, 1, 100);
    set_config(32768, 0, 0, 32767);
    offer_target(3, 1, -32768);
    offer_target(3, 1, -1);
  endtask

  // Random traffic over several settings; 44 in 100 targets land near the estimate.
  task automatic test_random_traffic();
    int sent, pick, leg, joint, target, slot, band, offset;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_config(32768, 0, 0, 0);
        1: set_config(0, 32767, 32767, 0);
        2: set_config(65535, 32767, 32767, 32767);
        3: set_config(1, 1, 1, 1);
        default: set_config($urandom_range(0, 3) == 0 ? $urandom_range(32769, 65535)
                                                      : $urandom_range(0, 32768),
                            $urandom_range(0, 1) ? $urandom_range(0, 2000) : 0,
                            $urandom_range(0, 1) ? $urandom_range(0, 2000) : 0,
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 300));
      endcase
      // Rotate idling so some phases run with no gaps on either side.
      tx_idle = (phase % 4) != 1 && (phase % 4) != 3;
      rx_idle = (phase % 4) != 1 && (phase % 4) != 2;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // Noise: leg or joint out of range.
          if ($urandom_range(0, 1)) begin
            leg = $urandom_range(LEGS, (1 << LEG_W) - 1);
            joint = $urandom_range(0, (1 << JOINT_W) - 1);
          end else begin
            leg = $urandom_range(0, LEGS - 1);
            joint = $urandom_range(JOINTS, (1 << JOINT_W) - 1);
          end
          offer_target(leg, joint, $urandom_range(0, 65535));
        end else begin
          leg = $urandom_range(0, LEGS - 1);
          joint = $urandom_range(0, JOINTS - 1);
          slot = leg * JOINTS + joint;
          if (pick < 50) begin
            band = band_reg;
            offset = $urandom_range(0, 2 * band + 4) - (band + 2);
            target = int'(est_store[slot]) + offset;
            if (target > POS_MAX) target = POS_MAX;
            if (target < POS_MIN) target = POS_MIN;
          end else if (pick < 56) begin
            target = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
          end else begin
            target = $urandom_range(0, 65535);
          end
          offer_target(leg, joint, target);
          sent++;
        end
      end
    end
  endtask

  // Hold the receiver off long enough to fill the pipe, keep offering,
  // then pause the sender until every result is back.
  task automatic test_output_stall();
    set_config(20000, 300, 300, 5);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    rx_hold_request = LONG_HOLD_CYCLES;
    for (int i = 0; i < 30; i++)
      offer_target($urandom_range(0, LEGS - 1), $urandom_range(0, JOINTS - 1),
                   $urandom_range(0, 65535));
    wait_idle();
    tx_idle = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_seed_and_extremes();
    test_gain_rounding();
    test_step_limits();
    test_deadband();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (errors == 0)
      $display("joint_lag_rate_limit_observer_test: done, clean");
    else
      $display("joint_lag_rate_limit_observer_test: done, errors");
    $finish;
  end

endmodule
